FILE: rtl/core/ipsa_pkg.sv
// shared types and codes of the ips patch stream applier
package ipsa_pkg;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // done status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_HDR   = 2'd1;
    localparam logic [1:0] ST_CAPACITY  = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_HEADER_PRESENT = 2'd0;
    localparam logic [1:0] REG_ROM_CAPACITY   = 2'd1;
    localparam logic [1:0] REG_CUR_ROM_SIZE   = 2'd2;

    localparam int APB_AW   = 4;
    localparam int SIZE_W   = 25;
    localparam int ADDR_W   = 24;
    localparam int LOC_W    = 26;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    localparam logic [23:0] EOF_MARK = 24'h454F46;

    // five bytes of the "PATCH" header
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h50;
            3'd1:    b = 8'h41;
            3'd2:    b = 8'h54;
            3'd3:    b = 8'h43;
            3'd4:    b = 8'h48;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    typedef struct packed {
        logic              header_present;
        logic [SIZE_W-1:0] cap;
        logic [SIZE_W-1:0] cur_rom_size;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_value;
        logic [15:0]       fill_count;
        logic [1:0]        status;
        logic [SIZE_W-1:0] new_rom_size;
        logic [9:0]        bank_count;
        logic              last_of_run;
    } res_t;

    typedef struct packed {
        logic v0;
        logic v1;
        res_t r0;
        res_t r1;
    } push_t;

endpackage

FILE: rtl/core/ips_patch_stream_applier.sv
// top level of the ips patch stream applier
//
//  port group  dir  content
//  s_*         in   one patch byte per request, tlast marks end of stream
//  m_*         out  byte write, fill run or done result per request
//  p*          in   apb register access
//
// One patch byte is taken per cycle while the result queue has room; with an empty
// queue its first result passes through the input register and the queue to m_*.
// A byte gives at most two results and the output port moves one per cycle,
// so two-result bytes fill the queue, and input is held once it holds over two.
// Reset is synchronous, active low, and clears parser state and the queue.
// Stalls on m_tready back up through a four-entry result queue.
module ips_patch_stream_applier #(
    parameter int ADDR_BITS       = 24,
    parameter int HEADER_SKIP     = 512,
    parameter int BANK_BYTES_LOG2 = 15
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // patch stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] patch_byte
    input  logic                         s_tlast,   // final_byte
    // results
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [23:0] write_address, [31:24] write_value, [47:32] fill_count,
    // [49:48] status, [74:50] new_rom_size, [84:75] bank_count, rest zero
    output logic [87:0]                  m_tdata,
    output logic [1:0]                   m_tuser,   // [1:0] kind
    output logic                         m_tlast,   // last_of_run
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ipsa_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    ipsa_pkg::cfg_t  cfg;
    ipsa_pkg::push_t push;
    ipsa_pkg::res_t  res;
    logic            space;

    ipsa_cfg #(
        .ADDR_BITS (ADDR_BITS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipsa_step #(
        .HEADER_SKIP     (HEADER_SKIP),
        .BANK_BYTES_LOG2 (BANK_BYTES_LOG2)
    ) u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata),
        .s_fin    (s_tlast),
        .cfg      (cfg),
        .space    (space),
        .push     (push)
    );

    ipsa_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res)
    );

    // result packing
    assign m_tuser = res.kind;
    assign m_tlast = res.last_of_run;
    assign m_tdata = {3'b0, res.bank_count, res.new_rom_size, res.status,
                      res.fill_count, res.write_value, res.write_address};

    // a done result always closes its request
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ipsa_pkg::KIND_DONE |-> m_tlast)
        else $error("done result not marked last");

    // byte writes stay below the clamped capacity
    a_write_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ipsa_pkg::KIND_WRITE |->
            {1'b0, m_tdata[23:0]} < cfg.cap)
        else $error("byte write at or past capacity");

    // fill runs are never empty and end within capacity
    a_fill_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ipsa_pkg::KIND_FILL |->
            m_tdata[47:32] != 16'd0 &&
            ({1'b0, m_tdata[23:0]} + {9'b0, m_tdata[47:32]}) <= cfg.cap)
        else $error("fill run empty or past capacity");

    // the second result slot is only used together with the first
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v1 |-> push.v0)
        else $error("second result pushed without first");

endmodule

FILE: rtl/core/ipsa_cfg.sv
// apb configuration registers and capacity clamp
module ipsa_cfg #(
    parameter int ADDR_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ipsa_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output ipsa_pkg::cfg_t               cfg
);
    localparam logic [ipsa_pkg::SIZE_W-1:0] ADDR_SPAN = ipsa_pkg::SIZE_W'(1) << ADDR_BITS;

    logic                          hdr_reg;
    logic [ipsa_pkg::SIZE_W-1:0]   cap_reg;
    logic [ipsa_pkg::SIZE_W-1:0]   size_reg;
    logic                          wr_en;
    logic [1:0]                    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg  <= 1'b0;
            cap_reg  <= ipsa_pkg::SIZE_W'(4194304);
            size_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                ipsa_pkg::REG_HEADER_PRESENT: hdr_reg  <= pwdata[0];
                ipsa_pkg::REG_ROM_CAPACITY:   cap_reg  <= pwdata[ipsa_pkg::SIZE_W-1:0];
                ipsa_pkg::REG_CUR_ROM_SIZE:   size_reg <= pwdata[ipsa_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (idx)
            ipsa_pkg::REG_HEADER_PRESENT: prdata = {31'b0, hdr_reg};
            ipsa_pkg::REG_ROM_CAPACITY:   prdata = {7'b0, cap_reg};
            ipsa_pkg::REG_CUR_ROM_SIZE:   prdata = {7'b0, size_reg};
            default:                      prdata = '0;
        endcase
    end

    // capacity never reaches past the address space
    assign cfg.header_present = hdr_reg;
    assign cfg.cap            = (cap_reg > ADDR_SPAN) ? ADDR_SPAN : cap_reg;
    assign cfg.cur_rom_size   = size_reg;

endmodule

FILE: rtl/core/ipsa_step.sv
// input register, patch parser state and per-byte result logic
module ipsa_step #(
    parameter int HEADER_SKIP     = 512,
    parameter int BANK_BYTES_LOG2 = 15
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_byte,
    input  logic            s_fin,
    input  ipsa_pkg::cfg_t  cfg,
    input  logic            space,
    output ipsa_pkg::push_t push
);
    localparam int END_W = ipsa_pkg::LOC_W + 1;
    localparam logic signed [ipsa_pkg::LOC_W-1:0] SKIP_S = ipsa_pkg::LOC_W'(HEADER_SKIP);

    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_OFS  = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_RLEN = 3'd4;
    localparam logic [2:0] PH_VAL  = 3'd5;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_fin_reg;
    logic       advance;

    // parser state
    logic [2:0]                          phase_reg, phase_next;
    logic [2:0]                          hidx_reg, hidx_next;
    logic [23:0]                         ofs_reg, ofs_next;
    logic [15:0]                         len_reg, len_next;
    logic [15:0]                         rem_reg, rem_next;
    logic signed [ipsa_pkg::LOC_W-1:0]   loc_reg, loc_next;
    logic [ipsa_pkg::ADDR_W-1:0]         hw_reg, hw_next;
    logic                                drop_reg, drop_next;

    assign advance  = in_vld_reg && space;
    assign s_tready = !in_vld_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_byte;
            in_fin_reg  <= s_fin;
        end
    end

    // one byte of parsing
    always_comb begin
        logic                                done;
        logic [1:0]                          done_st;
        logic                                dv;
        ipsa_pkg::res_t                      dres;
        ipsa_pkg::res_t                      fres;
        logic signed [ipsa_pkg::LOC_W-1:0]   cap_l;
        logic signed [END_W-1:0]             cap_e;
        logic signed [END_W-1:0]             start_e;
        logic signed [END_W-1:0]             end_e;
        logic signed [END_W-1:0]             span_e;
        logic signed [END_W-1:0]             last_e;
        logic [23:0]                         ofs_sh;
        logic [15:0]                         len_sh;
        logic [ipsa_pkg::SIZE_W-1:0]         size;
        logic [ipsa_pkg::SIZE_W-1:0]         banks;

        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        ofs_next   = ofs_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        loc_next   = loc_reg;
        hw_next    = hw_reg;
        drop_next  = drop_reg;
        done       = 1'b0;
        done_st    = ipsa_pkg::ST_OK;
        dv         = 1'b0;
        dres       = '0;
        fres       = '0;
        cap_l      = $signed({1'b0, cfg.cap});
        cap_e      = $signed({2'b0, cfg.cap});
        start_e    = loc_reg[ipsa_pkg::LOC_W-1] ? '0 : END_W'(loc_reg);
        end_e      = END_W'(loc_reg) + $signed({11'b0, len_reg});
        span_e     = '0;
        last_e     = '0;
        ofs_sh     = {ofs_reg[15:0], in_byte_reg};
        len_sh     = {len_reg[7:0], in_byte_reg};

        if (drop_reg) begin
            // wait for end of stream, then rearm
            if (in_fin_reg) begin
                phase_next = PH_HDR;
                hidx_next  = '0;
                ofs_next   = '0;
                len_next   = '0;
                rem_next   = '0;
                loc_next   = '0;
                hw_next    = '0;
                drop_next  = 1'b0;
            end
        end else begin
            unique case (phase_reg)
                PH_HDR: begin
                    if (hidx_reg > 3'd4 || in_byte_reg != ipsa_pkg::magic_byte(hidx_reg)) begin
                        done    = 1'b1;
                        done_st = ipsa_pkg::ST_BAD_HDR;
                    end else if (hidx_reg == 3'd4) begin
                        phase_next = PH_OFS;
                        hidx_next  = '0;
                        done       = in_fin_reg;
                        done_st    = ipsa_pkg::ST_OK;
                    end else begin
                        hidx_next = hidx_reg + 3'd1;
                        done      = in_fin_reg;
                        done_st   = ipsa_pkg::ST_TRUNCATED;
                    end
                end
                PH_OFS: begin
                    ofs_next = ofs_sh;
                    hidx_next = hidx_reg + 3'd1;
                    done      = in_fin_reg;
                    done_st   = ipsa_pkg::ST_TRUNCATED;
                    if (hidx_reg >= 3'd2) begin
                        hidx_next = '0;
                        if (ofs_sh == ipsa_pkg::EOF_MARK) begin
                            done    = 1'b1;
                            done_st = ipsa_pkg::ST_OK;
                        end else begin
                            loc_next   = $signed({2'b0, ofs_sh}) -
                                         (cfg.header_present ? SKIP_S : '0);
                            len_next   = '0;
                            phase_next = PH_LEN;
                        end
                    end
                end
                PH_LEN, PH_RLEN: begin
                    len_next  = len_sh;
                    hidx_next = hidx_reg + 3'd1;
                    done      = in_fin_reg;
                    done_st   = ipsa_pkg::ST_TRUNCATED;
                    if (hidx_reg >= 3'd1) begin
                        hidx_next = '0;
                        if (phase_reg == PH_RLEN) begin
                            phase_next = PH_VAL;
                        end else if (len_sh != 16'd0) begin
                            rem_next   = len_sh;
                            phase_next = PH_DATA;
                        end else begin
                            phase_next = PH_RLEN;
                        end
                    end
                end
                PH_DATA: begin
                    if (!loc_reg[ipsa_pkg::LOC_W-1] && loc_reg >= cap_l) begin
                        done    = 1'b1;
                        done_st = ipsa_pkg::ST_CAPACITY;
                    end else begin
                        // byte write when at or above zero
                        if (!loc_reg[ipsa_pkg::LOC_W-1]) begin
                            dv                 = 1'b1;
                            dres.kind          = ipsa_pkg::KIND_WRITE;
                            dres.write_address = loc_reg[ipsa_pkg::ADDR_W-1:0];
                            dres.write_value   = in_byte_reg;
                            if (loc_reg[ipsa_pkg::ADDR_W-1:0] > hw_reg) begin
                                hw_next = loc_reg[ipsa_pkg::ADDR_W-1:0];
                            end
                        end
                        loc_next = loc_reg + ipsa_pkg::LOC_W'(1);
                        rem_next = rem_reg - 16'd1;
                        done     = in_fin_reg;
                        if (rem_reg == 16'd1) begin
                            phase_next = PH_OFS;
                            done_st    = ipsa_pkg::ST_OK;
                        end else begin
                            done_st    = ipsa_pkg::ST_TRUNCATED;
                        end
                    end
                end
                PH_VAL: begin
                    phase_next = PH_OFS;
                    done       = in_fin_reg;
                    done_st    = ipsa_pkg::ST_OK;
                    if (end_e > start_e) begin
                        if (start_e >= cap_e) begin
                            done    = 1'b1;
                            done_st = ipsa_pkg::ST_CAPACITY;
                        end else begin
                            // clip the run at capacity
                            if (end_e > cap_e) begin
                                end_e   = cap_e;
                                done    = 1'b1;
                                done_st = ipsa_pkg::ST_CAPACITY;
                            end
                            span_e             = end_e - start_e;
                            last_e             = end_e - END_W'(1);
                            dv                 = 1'b1;
                            dres.kind          = ipsa_pkg::KIND_FILL;
                            dres.write_address = start_e[ipsa_pkg::ADDR_W-1:0];
                            dres.write_value   = in_byte_reg;
                            dres.fill_count    = span_e[15:0];
                            if (last_e[ipsa_pkg::ADDR_W-1:0] > hw_reg) begin
                                hw_next = last_e[ipsa_pkg::ADDR_W-1:0];
                            end
                        end
                    end
                    loc_next = end_e[ipsa_pkg::LOC_W-1:0];
                end
                default: begin
                    done    = 1'b1;
                    done_st = ipsa_pkg::ST_TRUNCATED;
                end
            endcase
            if (done) begin
                drop_next = 1'b1;
            end
        end

        // done result: grown size and bank count
        if ({1'b0, hw_next} >= cfg.cur_rom_size) begin
            size = {1'b0, hw_next} + ipsa_pkg::SIZE_W'(1);
        end else begin
            size = cfg.cur_rom_size;
        end
        banks              = size >> BANK_BYTES_LOG2;
        fres.kind          = ipsa_pkg::KIND_DONE;
        fres.status        = done_st;
        fres.new_rom_size  = size;
        fres.bank_count    = (banks > ipsa_pkg::SIZE_W'(1023)) ? 10'd1023 : banks[9:0];
        fres.last_of_run   = 1'b1;

        // pack results in order, last one flagged
        push = '0;
        if (advance) begin
            if (dv) begin
                push.v0             = 1'b1;
                push.r0             = dres;
                push.r0.last_of_run = !done;
                push.v1             = done;
                push.r1             = fres;
            end else begin
                push.v0 = done;
                push.r0 = fres;
            end
        end
    end

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR;
            hidx_reg  <= '0;
            ofs_reg   <= '0;
            len_reg   <= '0;
            rem_reg   <= '0;
            loc_reg   <= '0;
            hw_reg    <= '0;
            drop_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            ofs_reg   <= ofs_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            loc_reg   <= loc_next;
            hw_reg    <= hw_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

FILE: rtl/core/ipsa_outq.sv
// result queue: takes up to two results a cycle, hands out one while m_tready is high
module ipsa_outq (
    input  logic            aclk,
    input  logic            aresetn,
    input  ipsa_pkg::push_t push,
    output logic            space,
    output logic            m_tvalid,
    input  logic            m_tready,
    output ipsa_pkg::res_t  m_res
);
    ipsa_pkg::res_t                q_reg [ipsa_pkg::OQ_DEPTH];
    logic [ipsa_pkg::OQ_AW-1:0]    wr_reg, rd_reg;
    logic [ipsa_pkg::OQ_CW-1:0]    cnt_reg, cnt_next;
    logic [ipsa_pkg::OQ_CW-1:0]    n_push;
    logic                          pop;

    assign n_push   = ipsa_pkg::OQ_CW'(push.v0) + ipsa_pkg::OQ_CW'(push.v1);
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = cnt_reg != '0;
    assign m_res    = q_reg[rd_reg];
    assign space    = cnt_reg <= ipsa_pkg::OQ_CW'(ipsa_pkg::OQ_DEPTH - 2);
    assign cnt_next = cnt_reg + n_push - ipsa_pkg::OQ_CW'(pop);

    // storage
    always_ff @(posedge aclk) begin
        if (push.v0) begin
            q_reg[wr_reg] <= push.r0;
        end
        if (push.v1) begin
            q_reg[wr_reg + ipsa_pkg::OQ_AW'(1)] <= push.r1;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + n_push[ipsa_pkg::OQ_AW-1:0];
            rd_reg  <= rd_reg + ipsa_pkg::OQ_AW'(pop);
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: bench/ipsa_checker.sv
// result predictor and comparator for the ips patch stream applier
module ipsa_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] patch_byte
    input  logic                        s_tlast,   // final_byte
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [87:0]                 m_tdata,   // address, value, count, status, size, banks
    input  logic [1:0]                  m_tuser,   // [1:0] kind
    input  logic                        m_tlast,   // last_of_run
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [ipsa_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output int                          fail_count,
    output int                          pending,
    output logic                        armed
);
    localparam int ROM_SPAN = 1 << 24;
    localparam int COPIER_HDR = 512;
    localparam logic [39:0] MAGIC = "PATCH";

    typedef enum logic [2:0] {
        PS_MAGIC, PS_OFFSET, PS_LENGTH, PS_DATA, PS_RUN_LEN, PS_RUN_VAL
    } parse_state_t;

    // shadow registers
    logic        cfg_skip_hdr;
    logic [24:0] cfg_capacity;
    logic [24:0] cfg_rom_size;

    // shadow parser state
    parse_state_t pstate;
    int           byte_idx;
    logic [23:0]  ofs_acc;
    logic [15:0]  len_acc;
    logic [15:0]  bytes_left;
    int           loc;
    logic [23:0]  top_addr;
    logic         halted;

    ipsa_pkg::res_t expected_cmds[$];
    ipsa_pkg::res_t got;
    ipsa_pkg::res_t want;
    int   mismatches;
    int   results_seen;

    task automatic clear_parser();
        pstate     = PS_MAGIC;
        byte_idx   = 0;
        ofs_acc    = '0;
        len_acc    = '0;
        bytes_left = '0;
        loc        = 0;
        top_addr   = '0;
        halted     = 1'b0;
    endtask

    // done result, rom grows to cover the highest byte written
    function automatic ipsa_pkg::res_t done_result(input logic [1:0] st);
        ipsa_pkg::res_t r;
        logic [24:0]    size;
        r    = '0;
        size = cfg_rom_size;
        if ({1'b0, top_addr} >= cfg_rom_size)
            size = {1'b0, top_addr} + 25'd1;
        r.kind         = ipsa_pkg::KIND_DONE;
        r.status       = st;
        r.new_rom_size = size;
        // a 25-bit size never exceeds 1023 banks
        r.bank_count   = size[24:15];
        halted         = 1'b1;
        return r;
    endfunction

    function automatic string describe(input ipsa_pkg::res_t r);
        return $sformatf("kind=%0d addr=%h val=%h cnt=%0d st=%0d size=%0d banks=%0d last=%0d",
                         r.kind, r.write_address, r.write_value, r.fill_count, r.status,
                         r.new_rom_size, r.bank_count, r.last_of_run);
    endfunction

    // expected results of one patch byte
    task automatic predict_patch_byte(input logic [7:0] b, input logic fin);
        ipsa_pkg::res_t found[$];
        ipsa_pkg::res_t r;
        int   cap;
        int   fill_lo;
        int   fill_hi;
        bit   hit;
        cap = (cfg_capacity > 25'(ROM_SPAN)) ? ROM_SPAN : int'(cfg_capacity);
        if (halted) begin
            // stream already finished, only an end marker rearms
            if (fin)
                clear_parser();
            return;
        end
        case (pstate)
            PS_MAGIC: begin
                if (byte_idx > 4 || b != MAGIC[39-8*byte_idx -: 8]) begin
                    found.push_back(done_result(ipsa_pkg::ST_BAD_HDR));
                end else if (byte_idx == 4) begin
                    pstate   = PS_OFFSET;
                    byte_idx = 0;
                    if (fin)
                        found.push_back(done_result(ipsa_pkg::ST_OK));
                end else begin
                    byte_idx++;
                    if (fin)
                        found.push_back(done_result(ipsa_pkg::ST_TRUNCATED));
                end
            end
            PS_OFFSET: begin
                ofs_acc = {ofs_acc[15:0], b};
                byte_idx++;
                if (byte_idx >= 3 && ofs_acc == ipsa_pkg::EOF_MARK) begin
                    byte_idx = 0;
                    found.push_back(done_result(ipsa_pkg::ST_OK));
                end else begin
                    if (byte_idx >= 3) begin
                        byte_idx = 0;
                        loc      = int'(ofs_acc) - (cfg_skip_hdr ? COPIER_HDR : 0);
                        len_acc  = '0;
                        pstate   = PS_LENGTH;
                    end
                    if (fin)
                        found.push_back(done_result(ipsa_pkg::ST_TRUNCATED));
                end
            end
            PS_LENGTH, PS_RUN_LEN: begin
                len_acc = {len_acc[7:0], b};
                byte_idx++;
                if (byte_idx >= 2) begin
                    byte_idx = 0;
                    if (pstate == PS_RUN_LEN) begin
                        pstate = PS_RUN_VAL;
                    end else if (len_acc != '0) begin
                        bytes_left = len_acc;
                        pstate     = PS_DATA;
                    end else begin
                        pstate = PS_RUN_LEN;
                    end
                end
                if (fin)
                    found.push_back(done_result(ipsa_pkg::ST_TRUNCATED));
            end
            PS_DATA: begin
                if (loc >= 0 && loc >= cap) begin
                    found.push_back(done_result(ipsa_pkg::ST_CAPACITY));
                end else begin
                    // bytes below address zero are skipped
                    if (loc >= 0) begin
                        r               = '0;
                        r.kind          = ipsa_pkg::KIND_WRITE;
                        r.write_address = loc[23:0];
                        r.write_value   = b;
                        found.push_back(r);
                        if (loc > int'(top_addr))
                            top_addr = loc[23:0];
                    end
                    loc++;
                    bytes_left--;
                    if (bytes_left == '0) begin
                        pstate = PS_OFFSET;
                        if (fin)
                            found.push_back(done_result(ipsa_pkg::ST_OK));
                    end else if (fin) begin
                        found.push_back(done_result(ipsa_pkg::ST_TRUNCATED));
                    end
                end
            end
            PS_RUN_VAL: begin
                fill_lo = (loc < 0) ? 0 : loc;
                fill_hi = loc + int'(len_acc);
                hit     = 1'b0;
                pstate  = PS_OFFSET;
                if (fill_hi > fill_lo) begin
                    if (fill_lo >= cap) begin
                        hit = 1'b1;
                    end else begin
                        // clip the run at capacity
                        if (fill_hi > cap) begin
                            fill_hi = cap;
                            hit     = 1'b1;
                        end
                        r               = '0;
                        r.kind          = ipsa_pkg::KIND_FILL;
                        r.write_address = fill_lo[23:0];
                        r.write_value   = b;
                        r.fill_count    = 16'(fill_hi - fill_lo);
                        found.push_back(r);
                        if (fill_hi - 1 > int'(top_addr))
                            top_addr = 24'(fill_hi - 1);
                    end
                end
                loc = fill_hi;
                if (hit)
                    found.push_back(done_result(ipsa_pkg::ST_CAPACITY));
                else if (fin)
                    found.push_back(done_result(ipsa_pkg::ST_OK));
            end
            default: found.push_back(done_result(ipsa_pkg::ST_TRUNCATED));
        endcase
        // flag the last result of this request
        if (found.size() > 0) begin
            r = found.pop_back();
            r.last_of_run = 1'b1;
            found.push_back(r);
        end
        foreach (found[i])
            expected_cmds.push_back(found[i]);
    endtask

    // watch configuration, requests and results
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_skip_hdr = 1'b0;
            cfg_capacity = 25'd4194304;
            cfg_rom_size = '0;
            clear_parser();
            expected_cmds.delete();
            mismatches   = 0;
            results_seen = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    {ipsa_pkg::REG_HEADER_PRESENT, 2'b00}: cfg_skip_hdr = pwdata[0];
                    {ipsa_pkg::REG_ROM_CAPACITY, 2'b00}:   cfg_capacity = pwdata[24:0];
                    {ipsa_pkg::REG_CUR_ROM_SIZE, 2'b00}:   cfg_rom_size = pwdata[24:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_patch_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got               = '0;
                got.kind          = m_tuser;
                got.write_address = m_tdata[23:0];
                got.write_value   = m_tdata[31:24];
                got.fill_count    = m_tdata[47:32];
                got.status        = m_tdata[49:48];
                got.new_rom_size  = m_tdata[74:50];
                got.bank_count    = m_tdata[84:75];
                got.last_of_run   = m_tlast;
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with none expected: %s",
                                 results_seen, describe(got));
                end else begin
                    want = expected_cmds.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d differs", results_seen);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(got));
                        end
                    end
                end
                results_seen++;
            end
        end
        fail_count <= mismatches;
        pending    <= expected_cmds.size();
        armed      <= !halted && pstate == PS_MAGIC && byte_idx == 0;
    end

endmodule

FILE: bench/tb.sv
// stimulus and verdict for the ips patch stream applier
module tb;
    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = '0;    // [7:0] patch_byte
    logic                          s_tlast  = 1'b0;  // final_byte
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [87:0]                   m_tdata;          // address, value, count, status, size, banks
    logic [1:0]                    m_tuser;          // [1:0] kind
    logic                          m_tlast;          // last_of_run
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [ipsa_pkg::APB_AW-1:0]   paddr    = '0;
    logic [31:0]                   pwdata   = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    int   fail_count;
    int   pending;
    logic armed;

    // sender pacing
    int bytes_sent = 0;
    int burst_left = 0;
    bit no_gaps    = 1'b0;

    // receiver stall pattern
    int rdy_mode = 0;
    int rdy_left = 0;

    // register values of the current phase
    bit tb_skip = 1'b0;
    int tb_cap  = 4194304;
    int tb_rom  = 0;

    logic [8:0] patch_bytes[$];   // {final_byte, patch_byte}

    ips_patch_stream_applier dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ipsa_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending),
        .armed      (armed)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // result side stalls
    always @(posedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(20, 200);
        end
        rdy_left--;
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            2:       m_tready <= (rdy_left % 7) < 3;
            default: m_tready <= (rdy_left > 12);
        endcase
    end

    // one patch byte, in bursts with random gaps between them
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 15) == 0)
                no_gaps = !no_gaps;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until every expected result is out and the pipeline has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // send the built patch, then end-of-stream bytes until the parser is rearmed
    task automatic send_patch();
        foreach (patch_bytes[i])
            send_byte(patch_bytes[i][7:0], patch_bytes[i][8]);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (!armed) begin
            send_byte(8'($urandom), 1'b1);
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic mark_end();
        logic [8:0] tail;
        tail = patch_bytes.pop_back();
        patch_bytes.push_back({1'b1, tail[7:0]});
    endtask

    // offsets around the copier header, capacity and the top of the space
    function automatic logic [23:0] pick_offset();
        int base;
        case ($urandom_range(0, 5))
            0:       base = $urandom_range(0, 1023);
            1:       base = tb_cap + (tb_skip ? 512 : 0) - $urandom_range(0, 6);
            2:       base = $urandom;
            3:       base = 24'hFFFFFF - $urandom_range(0, 16);
            default: base = $urandom_range(0, 65535);
        endcase
        return base[23:0];
    endfunction

    task automatic build_patch();
        int          n_rec;
        int          len;
        int          cnt;
        int          cut;
        logic [23:0] ofs;
        logic [39:0] hdr;
        bit          closed;
        patch_bytes.delete();
        closed = 1'b0;
        hdr    = "PATCH";
        // line noise
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 12)) patch_bytes.push_back({1'b0, 8'($urandom)});
            if ($urandom_range(0, 1) == 1)
                mark_end();
            return;
        end
        for (int i = 0; i < 5; i++)
            patch_bytes.push_back({1'b0, hdr[39-8*i -: 8]});
        if ($urandom_range(0, 15) == 0)
            patch_bytes[$urandom_range(0, 4)] = {1'b0, 8'($urandom)};
        n_rec = $urandom_range(0, 5);
        for (int k = 0; k < n_rec && !closed; k++) begin
            ofs = pick_offset();
            patch_bytes.push_back({1'b0, ofs[23:16]});
            patch_bytes.push_back({1'b0, ofs[15:8]});
            patch_bytes.push_back({1'b0, ofs[7:0]});
            if ($urandom_range(0, 2) == 0) begin
                // run record
                case ($urandom_range(0, 7))
                    0:       cnt = 0;
                    1:       cnt = $urandom_range(0, 65535);
                    2:       cnt = 65535;
                    default: cnt = $urandom_range(1, 300);
                endcase
                patch_bytes.push_back(9'h000);
                patch_bytes.push_back(9'h000);
                patch_bytes.push_back({1'b0, 8'(cnt >> 8)});
                patch_bytes.push_back({1'b0, 8'(cnt)});
                patch_bytes.push_back({1'b0, 8'($urandom)});
            end else begin
                if ($urandom_range(0, 24) == 0)
                    len = $urandom_range(64, 65535);
                else if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(1, 40);
                else
                    len = $urandom_range(1, 12);
                patch_bytes.push_back({1'b0, 8'(len >> 8)});
                patch_bytes.push_back({1'b0, 8'(len)});
                if (len > 40) begin
                    // long record: stream cut after a few bytes
                    repeat ($urandom_range(1, 4)) patch_bytes.push_back({1'b0, 8'($urandom)});
                    mark_end();
                    closed = 1'b1;
                end else begin
                    repeat (len) patch_bytes.push_back({1'b0, 8'($urandom)});
                end
            end
        end
        if (!closed) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    patch_bytes.push_back({1'b0, ipsa_pkg::EOF_MARK[23:16]});
                    patch_bytes.push_back({1'b0, ipsa_pkg::EOF_MARK[15:8]});
                    patch_bytes.push_back({1'b0, ipsa_pkg::EOF_MARK[7:0]});
                    if ($urandom_range(0, 1) == 1)
                        mark_end();
                end
                2: mark_end();
                default: begin
                    // truncated anywhere in the stream
                    cut = $urandom_range(0, patch_bytes.size() - 1);
                    while (patch_bytes.size() > cut + 1)
                        void'(patch_bytes.pop_back());
                    mark_end();
                end
            endcase
        end
    endtask

    initial begin
        int target;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty patch on an empty rom: size grows to one byte
        patch_bytes = '{9'h050, 9'h041, 9'h054, 9'h043, 9'h048, 9'h045, 9'h04F, 9'h046};
        send_patch();
        // byte write, then a run clipped at the default capacity
        patch_bytes = '{9'h050, 9'h041, 9'h054, 9'h043, 9'h048,
                        9'h000, 9'h000, 9'h010, 9'h000, 9'h001, 9'h0AB,
                        9'h03F, 9'h0FF, 9'h0FE, 9'h000, 9'h000, 9'h000, 9'h005, 9'h0CC};
        send_patch();

        target = bytes_sent;
        for (int p = 0; p < 10; p++) begin
            settle();
            case (p)
                0: begin
                    tb_skip = 1'b1;
                    tb_cap  = 1 << 24;
                    tb_rom  = 0;
                end
                1: begin
                    tb_skip = 1'b0;
                    tb_cap  = 0;
                    tb_rom  = 1 << 24;
                end
                2: begin
                    tb_skip = 1'b1;
                    tb_cap  = 1;
                    tb_rom  = 1;
                end
                3: begin
                    tb_skip = 1'b0;
                    tb_cap  = $urandom_range(512, 8192);
                    tb_rom  = $urandom_range(0, 8192);
                end
                default: begin
                    tb_skip = $urandom_range(0, 1);
                    tb_cap  = ($urandom_range(0, 3) == 0) ? (1 << 24)
                                                          : $urandom_range(0, 1 << 24);
                    tb_rom  = $urandom_range(0, 1 << 24);
                end
            endcase
            write_reg(ipsa_pkg::REG_HEADER_PRESENT, 32'(tb_skip));
            write_reg(ipsa_pkg::REG_ROM_CAPACITY, 32'(tb_cap));
            write_reg(ipsa_pkg::REG_CUR_ROM_SIZE, 32'(tb_rom));
            target += 152;
            while (bytes_sent < target) begin
                build_patch();
                send_patch();
            end
        end

        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial begin
        #10000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ipsa_pkg.sv
rtl/core/ipsa_cfg.sv
rtl/core/ipsa_step.sv
rtl/core/ipsa_outq.sv
rtl/core/ips_patch_stream_applier.sv
bench/ipsa_checker.sv
bench/tb.sv
